FILE: design/mau_pkg.sv
`default_nettype none
package mau_pkg;
    localparam int unsigned MW = 31;
    localparam logic [MW-1:0] RESET_MODULUS = 31'd998244353;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_POW = 3'd4,
        CMD_INV = 3'd5,
        CMD_NEG = 3'd6,
        CMD_RED = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        MOP_MUL = 2'd0,
        MOP_RED = 2'd1,
        MOP_DIV = 2'd2
    } mop_t;

    typedef struct packed {
        logic        start;
        mop_t        op;
        logic [63:0] x;
        logic [MW-1:0] y;
    } mreq_t;

    typedef struct packed {
        logic          done;
        logic [63:0]   quo;
        logic [MW-1:0] rem;
    } mrsp_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RA, ST_RAW, ST_RB, ST_RBW, ST_DISP, ST_PMUL, ST_PMULW,
        ST_PSQ, ST_PSQW, ST_IDIV, ST_IDIVW, ST_IFIX, ST_FMUL, ST_FMULW, ST_OUT
    } state_t;
endpackage
`default_nettype wire

FILE: design/modular_arithmetic_unit_top.sv
`default_nettype none
// Channel   Direction  Fields
// s_        in         command, operand_a, operand_b
// m_        out        result, operands_equal
// cfg_      in         modulus
// Each operand reduction and each Euclid step is one divide pass of the shared
// unit, and each product is one multiply-then-reduce pass. Reset is synchronous,
// active low. s_ready is low while a request is in work, a result waits or a
// configuration write is offered.
module modular_arithmetic_unit_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic signed [63:0] s_operand_a,
    input  wire logic signed [63:0] s_operand_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [30:0]      m_result,
    output logic             m_operands_equal,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [30:0] cfg_modulus
);
    localparam int W = mau_pkg::MW;
    mau_pkg::state_t state_reg, state_next;
    mau_pkg::mreq_t req;
    mau_pkg::mrsp_t rsp;
    logic [W-1:0] mod_reg, m_eff, a_reg, b_reg, acc_reg, sq_reg, res_reg;
    logic [63:0] e_reg, ina_reg, inb_reg;
    logic [2:0] cmd_reg;
    logic neg_reg;
    logic signed [32:0] ex_reg, ey_reg, eu_reg, ev_reg;
    logic [63:0] mag_b;
    logic signed [64:0] qv;
    logic signed [32:0] nu;

    assign m_eff = (mod_reg == '0) ? W'(1) : mod_reg;
    assign mag_b = s_operand_b[63] ? 64'(-s_operand_b) : s_operand_b;
    assign cfg_ready = (state_reg == mau_pkg::ST_IDLE);
    assign s_ready = (state_reg == mau_pkg::ST_IDLE) && !cfg_valid;
    assign m_valid = (state_reg == mau_pkg::ST_OUT);
    assign m_result = res_reg;
    assign m_operands_equal = (a_reg == b_reg);

    mau_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    function automatic logic [W-1:0] fix(input logic [W-1:0] r, input logic neg,
                                         input logic [W-1:0] m);
        fix = (neg && r != '0) ? m - r : r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mau_pkg::ST_IDLE;
            mod_reg <= mau_pkg::RESET_MODULUS;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) mod_reg <= cfg_modulus;
        end
    end

    always_comb begin
        qv = signed'({1'b0, rsp.quo[W-1:0]}) * ev_reg;
        nu = eu_reg - 33'(qv);
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            mau_pkg::ST_IDLE: if (s_valid && s_ready) begin
                cmd_reg <= s_command;
                ina_reg <= s_operand_a;
                inb_reg <= s_operand_b;
                e_reg <= mag_b;
                neg_reg <= s_operand_b[63];
            end
            mau_pkg::ST_RAW: if (rsp.done) a_reg <= fix(rsp.rem, ina_reg[63], m_eff);
            mau_pkg::ST_RBW: if (rsp.done) b_reg <= fix(rsp.rem, inb_reg[63], m_eff);
            mau_pkg::ST_DISP: begin
                acc_reg <= (m_eff == W'(1)) ? '0 : W'(1);
                sq_reg <= a_reg;
                case (mau_pkg::cmd_t'(cmd_reg))
                    mau_pkg::CMD_ADD: begin
                        res_reg <= ({1'b0, a_reg} + {1'b0, b_reg} >= {1'b0, m_eff}) ?
                            W'({1'b0, a_reg} + {1'b0, b_reg} - {1'b0, m_eff}) : a_reg + b_reg;
                    end
                    mau_pkg::CMD_SUB: res_reg <= (a_reg >= b_reg) ? a_reg - b_reg
                                                                  : a_reg + m_eff - b_reg;
                    mau_pkg::CMD_NEG: res_reg <= (a_reg == '0) ? '0 : m_eff - a_reg;
                    mau_pkg::CMD_RED: res_reg <= a_reg;
                    default: res_reg <= a_reg;
                endcase
                ex_reg <= 33'(cmd_reg == mau_pkg::CMD_INV ? a_reg : b_reg);
                ey_reg <= 33'(m_eff);
                eu_reg <= 33'sd1;
                ev_reg <= 33'sd0;
            end
            mau_pkg::ST_PMULW: if (rsp.done) acc_reg <= rsp.rem;
            mau_pkg::ST_PSQW: if (rsp.done) begin
                sq_reg <= rsp.rem;
                e_reg <= e_reg >> 1;
                if (e_reg == 64'd1 && neg_reg) begin
                    ex_reg <= 33'(acc_reg);
                end
            end
            mau_pkg::ST_IDIVW: if (rsp.done) begin
                ex_reg <= ey_reg;
                ey_reg <= 33'(rsp.rem);
                eu_reg <= ev_reg;
                ev_reg <= nu;
            end
            mau_pkg::ST_IFIX: begin
                if (m_eff == W'(1)) res_reg <= '0;
                else if (eu_reg < 0) res_reg <= W'(eu_reg + 33'(m_eff));
                else res_reg <= W'(eu_reg);
                if (cmd_reg == mau_pkg::CMD_POW) acc_reg <= W'(0);
            end
            mau_pkg::ST_FMULW: if (rsp.done) res_reg <= rsp.rem;
            default: ;
        endcase
        if (state_reg == mau_pkg::ST_PSQ && e_reg == '0) begin
            res_reg <= acc_reg;
        end
    end

    // Euclid divide uses quotient of x/y; x,y nonnegative so unsigned is exact.
    always_comb begin
        state_next = state_reg;
        req = '0;
        req.y = m_eff;
        case (state_reg)
            mau_pkg::ST_IDLE: if (s_valid && s_ready) state_next = mau_pkg::ST_RA;
            mau_pkg::ST_RA: begin
                req.start = 1'b1; req.op = mau_pkg::MOP_RED;
                req.x = ina_reg[63] ? 64'(-ina_reg) : ina_reg;
                state_next = mau_pkg::ST_RAW;
            end
            mau_pkg::ST_RAW: if (rsp.done) state_next = mau_pkg::ST_RB;
            mau_pkg::ST_RB: begin
                req.start = 1'b1; req.op = mau_pkg::MOP_RED;
                req.x = inb_reg[63] ? 64'(-inb_reg) : inb_reg;
                state_next = mau_pkg::ST_RBW;
            end
            mau_pkg::ST_RBW: if (rsp.done) state_next = mau_pkg::ST_DISP;
            mau_pkg::ST_DISP: begin
                case (mau_pkg::cmd_t'(cmd_reg))
                    mau_pkg::CMD_MUL: state_next = mau_pkg::ST_FMUL;
                    mau_pkg::CMD_DIV, mau_pkg::CMD_INV: state_next = mau_pkg::ST_IDIV;
                    mau_pkg::CMD_POW: state_next = mau_pkg::ST_PSQ;
                    default: state_next = mau_pkg::ST_OUT;
                endcase
            end
            mau_pkg::ST_PSQ: begin
                if (e_reg == '0) begin
                    state_next = neg_reg ? mau_pkg::ST_IDIV : mau_pkg::ST_OUT;
                end else if (e_reg[0]) begin
                    req.start = 1'b1; req.op = mau_pkg::MOP_MUL;
                    req.x = {2'b00, acc_reg, sq_reg};
                    state_next = mau_pkg::ST_PMULW;
                end else begin
                    req.start = 1'b1; req.op = mau_pkg::MOP_MUL;
                    req.x = {2'b00, sq_reg, sq_reg};
                    state_next = mau_pkg::ST_PSQW;
                end
            end
            mau_pkg::ST_PMULW: if (rsp.done) state_next = mau_pkg::ST_PMUL;
            mau_pkg::ST_PMUL: begin
                req.start = 1'b1; req.op = mau_pkg::MOP_MUL;
                req.x = {2'b00, sq_reg, sq_reg};
                state_next = mau_pkg::ST_PSQW;
            end
            mau_pkg::ST_PSQW: if (rsp.done) state_next = mau_pkg::ST_PSQ;
            mau_pkg::ST_IDIV: begin
                if (ey_reg == 0) state_next = mau_pkg::ST_IFIX;
                else begin
                    req.start = 1'b1; req.op = mau_pkg::MOP_DIV;
                    req.x = 64'(ex_reg[W:0]); req.y = W'(ey_reg);
                    state_next = mau_pkg::ST_IDIVW;
                end
            end
            mau_pkg::ST_IDIVW: if (rsp.done) state_next = mau_pkg::ST_IDIV;
            mau_pkg::ST_IFIX: state_next = (cmd_reg == mau_pkg::CMD_DIV) ? mau_pkg::ST_FMUL
                                                                       : mau_pkg::ST_OUT;
            mau_pkg::ST_FMUL: begin
                req.start = 1'b1; req.op = mau_pkg::MOP_MUL;
                req.x = {2'b00, a_reg, (cmd_reg == mau_pkg::CMD_DIV) ? res_reg : b_reg};
                state_next = mau_pkg::ST_FMULW;
            end
            mau_pkg::ST_FMULW: if (rsp.done) state_next = mau_pkg::ST_OUT;
            mau_pkg::ST_OUT: if (m_ready) state_next = mau_pkg::ST_IDLE;
            default: state_next = mau_pkg::ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result < m_eff || m_eff == W'(1))
        else $error("result not reduced");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");
endmodule
`default_nettype wire

FILE: design/mau_divider.sv
`default_nettype none
// Shared unit: multiply two 31-bit values packed in x[61:31] and x[30:0]
// (shift-add, one bit a cycle) and then divide the product by y, or divide
// a 64-bit value by a 31-bit one (restoring, one quotient bit a cycle).
module mau_divider (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire mau_pkg::mreq_t req,
    output mau_pkg::mrsp_t     rsp
);
    logic [63:0] prod_reg, mcand_reg, quo_reg;
    logic [mau_pkg::MW-1:0] mplier_reg, div_reg, rem_reg;
    logic [6:0] cnt_reg;
    logic busy_reg, phase_reg, done_reg;
    logic [mau_pkg::MW:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, div_reg};
    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;
    assign rsp.rem = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            div_reg <= req.y;
            rem_reg <= '0;
            if (req.op == mau_pkg::MOP_MUL) begin
                phase_reg <= 1'b0;
                prod_reg <= '0;
                mcand_reg <= 64'(req.x[2*mau_pkg::MW-1:mau_pkg::MW]);
                mplier_reg <= req.x[mau_pkg::MW-1:0];
                cnt_reg <= 7'(mau_pkg::MW);
            end else begin
                phase_reg <= 1'b1;
                quo_reg <= req.x;
                cnt_reg <= 7'd64;
            end
        end else if (busy_reg && !phase_reg) begin
            done_reg <= 1'b0;
            prod_reg <= mplier_reg[0] ? prod_reg + mcand_reg : prod_reg;
            mplier_reg <= mplier_reg >> 1;
            mcand_reg <= mcand_reg << 1;
            if (cnt_reg == 7'd1) begin
                phase_reg <= 1'b1;
                quo_reg <= mplier_reg[0] ? prod_reg + mcand_reg : prod_reg;
                cnt_reg <= 7'd64;
            end else begin
                cnt_reg <= cnt_reg - 7'd1;
            end
        end else if (busy_reg) begin
            if (!trial[mau_pkg::MW]) begin
                rem_reg <= trial[mau_pkg::MW-1:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[mau_pkg::MW-2:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 7'd1;
            busy_reg <= (cnt_reg != 7'd1);
            done_reg <= (cnt_reg == 7'd1);
        end else begin
            done_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

FILE: test/modular_arithmetic_unit_top_tb.sv
`default_nettype none
module modular_arithmetic_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        mau_pkg::cmd_t cmd;
        logic [63:0]   a;
        logic [63:0]   b;
    } request_t;

    typedef struct {
        logic [30:0] res;
        logic        eq;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command = '0;
    logic signed [63:0] s_operand_a = '0;
    logic signed [63:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [30:0] m_result;
    logic        m_operands_equal;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_modulus = '0;

    request_t    pending_requests[$];
    answer_t     expected_answers[$];
    logic [30:0] modulus_copy = mau_pkg::RESET_MODULUS;
    int          n_issued = 0;
    int          n_accepted = 0;
    int          n_answered = 0;
    int          n_errors = 0;
    int          hold_cycles = 0;
    bit          hold_done = 1'b0;
    bit          req_taken = 1'b0;
    int          cmd_seen[8];

    modular_arithmetic_unit_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result),
        .m_operands_equal(m_operands_equal),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_modulus(cfg_modulus)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint unsigned reduce_op(logic [63:0] x, longint unsigned m);
        longint unsigned r;
        if (x[63]) begin
            r = (64'd0 - x) % m;
            return (r == 0) ? 0 : m - r;
        end
        return x % m;
    endfunction

    function automatic longint unsigned euclid_inverse(longint unsigned a,
                                                       longint unsigned m);
        longint x, y, u, v, q, nx, nu;
        x = a;
        y = m;
        u = 1;
        v = 0;
        while (y != 0) begin
            q = x / y;
            nx = x - q * y;
            nu = u - q * v;
            x = y;
            y = nx;
            u = v;
            v = nu;
        end
        u = u % longint'(m);
        if (u < 0) u = u + longint'(m);
        return u;
    endfunction

    function automatic longint unsigned power_mod(longint unsigned base,
                                                  logic [63:0] e, longint unsigned m);
        longint unsigned acc, sq;
        acc = 1 % m;
        sq = base % m;
        while (e != 0) begin
            if (e[0]) acc = acc * sq % m;
            sq = sq * sq % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic answer_t modular_result(request_t rq, logic [30:0] modulus);
        longint unsigned m, a, b, r;
        logic [63:0] mag;
        answer_t ans;
        m = (modulus == 0) ? 1 : modulus;
        a = reduce_op(rq.a, m);
        b = reduce_op(rq.b, m);
        case (rq.cmd)
            mau_pkg::CMD_ADD: r = (a + b) % m;
            mau_pkg::CMD_SUB: r = (a + m - b) % m;
            mau_pkg::CMD_MUL: r = a * b % m;
            mau_pkg::CMD_DIV: r = a * euclid_inverse(b, m) % m;
            mau_pkg::CMD_POW: begin
                mag = rq.b[63] ? 64'd0 - rq.b : rq.b;
                r = power_mod(a, mag, m);
                if (rq.b[63]) r = euclid_inverse(r, m);
            end
            mau_pkg::CMD_INV: r = euclid_inverse(a, m);
            mau_pkg::CMD_NEG: r = (m - a) % m;
            default: r = a;
        endcase
        ans.res = r[30:0];
        ans.eq = (a == b);
        return ans;
    endfunction

    function automatic bit calm_window();
        return n_answered >= 400 && n_answered < 480;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_answers.push_back(modular_result(
                '{mau_pkg::cmd_t'(s_command), s_operand_a, s_operand_b}, modulus_copy));
            n_accepted++;
            req_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        request_t rq;
        if (s_valid && !req_taken) begin
        end else if (aresetn && pending_requests.size() > 0 &&
                     (calm_window() || $urandom_range(99) >= 34)) begin
            rq = pending_requests.pop_front();
            s_valid <= 1'b1;
            s_command <= rq.cmd;
            s_operand_a <= rq.a;
            s_operand_b <= rq.b;
        end else begin
            s_valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    always @(negedge aclk) begin
        if (!hold_done && n_accepted >= 300) begin
            hold_done = 1'b1;
            hold_cycles = 30000;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && (calm_window() || $urandom_range(99) >= 34);
        end
    end

    always @(posedge aclk) begin
        answer_t exp_ans;
        if (aresetn && m_valid && m_ready) begin
            n_answered++;
            if (expected_answers.size() == 0) begin
                $error("result without a pending request: result=%0d", m_result);
                n_errors++;
            end else begin
                exp_ans = expected_answers.pop_front();
                if (m_result !== exp_ans.res) begin
                    $error("result: expected %0d, actual %0d", exp_ans.res, m_result);
                    n_errors++;
                end
                if (m_operands_equal !== exp_ans.eq) begin
                    $error("operands_equal: expected %0d, actual %0d",
                           exp_ans.eq, m_operands_equal);
                    n_errors++;
                end
            end
        end
    end

    task automatic add_request(mau_pkg::cmd_t cmd, logic [63:0] a, logic [63:0] b);
        pending_requests.push_back('{cmd, a, b});
        cmd_seen[cmd]++;
        n_issued++;
    endtask

    function automatic logic [63:0] random_operand(logic [30:0] modulus);
        logic [63:0] k;
        k = {$urandom, $urandom} >> $urandom_range(63, 30);
        case ($urandom_range(5))
            0, 1: return {$urandom, $urandom};
            2: return 64'(longint'($urandom_range(40)) - 20);
            3: return k * modulus + $urandom_range(2);
            4: return 64'd0 - k * modulus;
            default: begin
                case ($urandom_range(3))
                    0: return 64'h7fff_ffff_ffff_ffff;
                    1: return 64'h8000_0000_0000_0001;
                    2: return 64'(modulus) - 1;
                    default: return 64'h8000_0000_0000_0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [63:0] random_exponent();
        case ($urandom_range(7))
            0: return {$urandom, $urandom};
            1: return 64'h8000_0000_0000_0000;
            2, 3: return 64'(longint'($urandom_range(2000)) - 1000);
            default: return 64'(longint'($urandom_range(40)) - 20);
        endcase
    endfunction

    task automatic wait_idle();
        wait (n_answered == n_issued && pending_requests.size() == 0);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_modulus(logic [30:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_modulus <= value;
        do @(posedge aclk); while (!cfg_ready);
        modulus_copy = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        logic [63:0] a, b;
        mau_pkg::cmd_t cmd;
        repeat (count) begin
            cmd = mau_pkg::cmd_t'($urandom_range(7));
            a = random_operand(modulus_copy);
            b = (cmd == mau_pkg::CMD_POW) ? random_exponent() :
                ($urandom_range(9) == 0) ? a + 64'(modulus_copy) :
                random_operand(modulus_copy);
            add_request(cmd, a, b);
        end
    endtask

    initial begin
        logic [63:0] m64;
        logic [30:0] moduli[6];
        moduli = '{31'd7, 31'd2147483647, 31'd2, 31'd12,
                   31'd1000000007, mau_pkg::RESET_MODULUS};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        m64 = 64'(modulus_copy);
        add_request(mau_pkg::CMD_ADD, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
        add_request(mau_pkg::CMD_SUB, 64'd0, 64'd1);
        add_request(mau_pkg::CMD_MUL, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
        add_request(mau_pkg::CMD_DIV, 64'd5, 64'd0);
        add_request(mau_pkg::CMD_DIV, 64'd5, m64 * 3);
        add_request(mau_pkg::CMD_DIV, 64'd7, 64'd3);
        add_request(mau_pkg::CMD_POW, 64'd0, 64'd0);
        add_request(mau_pkg::CMD_POW, 64'd3, 64'hffff_ffff_ffff_ffff);
        add_request(mau_pkg::CMD_POW, 64'd3, 64'h8000_0000_0000_0000);
        add_request(mau_pkg::CMD_POW, 64'hffff_ffff_ffff_fffe, 64'h7fff_ffff_ffff_ffff);
        add_request(mau_pkg::CMD_INV, 64'd0, 64'd0);
        add_request(mau_pkg::CMD_INV, 64'd2, 64'd9);
        add_request(mau_pkg::CMD_NEG, 64'd0, 64'd0);
        add_request(mau_pkg::CMD_NEG, 64'd0 - m64, 64'd1);
        add_request(mau_pkg::CMD_RED, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        add_request(mau_pkg::CMD_RED, 64'd0 - m64 * 5, 64'd0);
        add_request(mau_pkg::CMD_RED, m64 - 1, 64'hffff_ffff_ffff_ffff);
        add_request(mau_pkg::CMD_RED, 64'hffff_ffff_ffff_ffff, 64'd0 - 64'd1);
        add_request(mau_pkg::CMD_ADD, 64'd4, 64'd4 + m64);
        random_phase(80);
        wait_idle();
        foreach (moduli[i]) begin
            write_modulus(moduli[i]);
            if (moduli[i] == 31'd12) begin
                add_request(mau_pkg::CMD_INV, 64'd4, 64'd0);
                add_request(mau_pkg::CMD_DIV, 64'd5, 64'd6);
                add_request(mau_pkg::CMD_POW, 64'd2, 64'hffff_ffff_ffff_fffd);
            end
            random_phase(92);
            wait_idle();
        end
        repeat (2000) @(posedge aclk);
        $display("tb: %0d requests over 7 modulus settings", n_accepted);
        $display("tb: commands add..reduce %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3],
                 cmd_seen[4], cmd_seen[5], cmd_seen[6], cmd_seen[7]);
        $display("tb: %0d results checked, %0d mismatches", n_answered, n_errors);
        if (n_errors == 0 && expected_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(64'd2_000_000_000);
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
design/mau_pkg.sv
design/mau_divider.sv
design/modular_arithmetic_unit_top.sv
test/modular_arithmetic_unit_top_tb.sv
